// ===== design/trp_pkg.sv =====
// Shared types and constants for the touch report parser.
package trp_pkg;

    // Status byte decode
    localparam logic [7:0] STATUS_MASK = 8'h81;
    localparam logic [7:0] STATUS_DOWN = 8'h81;
    localparam logic [7:0] STATUS_UP   = 8'h80;

    // Widths
    localparam int RAW_W    = 15;   // high*128 + low + 1, up to 16384
    localparam int DATA_W   = 7;    // payload bits kept from each data byte
    localparam int SCALE_W  = 16;   // Q0.16 reciprocal
    localparam int PIXEL_W  = 14;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = RAW_W + SCALE_W;

    // Configuration register indexes
    localparam logic [1:0] CFG_X_SCALE     = 2'd0;
    localparam logic [1:0] CFG_Y_SCALE     = 2'd1;
    localparam logic [1:0] CFG_REPORT_MODE = 2'd2;

    // Report mode codes; any other code reports both events
    localparam logic [1:0] MODE_DOWN_ONLY = 2'd0;
    localparam logic [1:0] MODE_UP_ONLY   = 2'd1;
    localparam logic [1:0] MODE_BOTH      = 2'd2;

    // Reset values
    localparam logic [SCALE_W-1:0] X_SCALE_RST = 16'd12800;
    localparam logic [SCALE_W-1:0] Y_SCALE_RST = 16'd7680;

    // One captured report, raw coordinates
    typedef struct packed {
        logic [RAW_W-1:0] x_raw;
        logic [RAW_W-1:0] y_raw;
        logic             pen_down;
    } frame_t;

    // Scaled result
    typedef struct packed {
        logic [PIXEL_W-1:0] x_pixel;
        logic [PIXEL_W-1:0] y_pixel;
        logic               pen_down;
    } report_t;

endpackage

// ===== design/touch_report_parser_core.sv =====
// Top level of the touch report parser: config registers, parser and scaler.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] rx_byte
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata x_pixel,y_pixel; tuser pen_down
//  cfg       in   cfg_valid / cfg_ready          cfg_addr index, cfg_wdata value
//
// One byte is taken per cycle while s_axis_tready is high. A report leaves through two
// registers after its last (y high) byte: the raw frame register, then the scale
// multipliers into the result register. Reset is synchronous, active low, and clears the
// parser to idle and the scales and mode to their defaults. A stall on m_axis
// backs up through the two registers; s_axis_tready drops only when both hold.
module touch_report_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    // report stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [13:0] x_pixel, [27:14] y_pixel, [31:28] zero
    output logic        m_axis_tuser,    // [0] pen_down
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [trp_pkg::SCALE_W-1:0] x_scale_reg, x_scale_next;
    logic [trp_pkg::SCALE_W-1:0] y_scale_reg, y_scale_next;
    logic [1:0]                  mode_reg, mode_next;

    logic             frame_valid, frame_ready;
    trp_pkg::frame_t  frame;
    trp_pkg::report_t report;

    // Config writes always complete; index three is dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        x_scale_next = x_scale_reg;
        y_scale_next = y_scale_reg;
        mode_next    = mode_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                trp_pkg::CFG_X_SCALE:     x_scale_next = cfg_wdata;
                trp_pkg::CFG_Y_SCALE:     y_scale_next = cfg_wdata;
                trp_pkg::CFG_REPORT_MODE: mode_next    = cfg_wdata[1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_scale_reg <= trp_pkg::X_SCALE_RST;
            y_scale_reg <= trp_pkg::Y_SCALE_RST;
            mode_reg    <= trp_pkg::MODE_DOWN_ONLY;
        end else begin
            x_scale_reg <= x_scale_next;
            y_scale_reg <= y_scale_next;
            mode_reg    <= mode_next;
        end
    end

    // Status detect and data byte capture
    trp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .report_mode (mode_reg),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    // Reciprocal multiply, truncate to pixels
    trp_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (frame_valid),
        .in_ready  (frame_ready),
        .frame     (frame),
        .x_scale   (x_scale_reg),
        .y_scale   (y_scale_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .report    (report)
    );

    assign m_axis_tdata = {4'b0, report.y_pixel, report.x_pixel};
    assign m_axis_tuser = report.pen_down;

    a_frame_held: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_valid && !frame_ready |=> frame_valid)
        else $error("raw frame dropped while scaler stalled");

    a_mode_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && (cfg_addr == trp_pkg::CFG_REPORT_MODE) |=> mode_reg == $past(cfg_wdata[1:0]))
        else $error("report mode write not taken");

endmodule

// ===== design/trp_parser.sv =====
// Byte parser: status detect, data byte capture, raw frame register.
module trp_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic [1:0]            report_mode,
    output logic                  frame_valid,
    input  logic                  frame_ready,
    output trp_pkg::frame_t       frame
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_X_LO = 3'd1;
    localparam logic [2:0] PH_X_HI = 3'd2;
    localparam logic [2:0] PH_Y_LO = 3'd3;
    localparam logic [2:0] PH_Y_HI = 3'd4;

    logic [2:0]                     phase_reg, phase_next;
    logic [trp_pkg::DATA_W-1:0]     low_reg, low_next;
    logic [trp_pkg::RAW_W-1:0]      x_raw_reg, x_raw_next;
    logic                           down_reg, down_next;
    logic                           frame_valid_reg, frame_valid_next;
    trp_pkg::frame_t                frame_reg, frame_next;

    logic                           accept;
    logic [trp_pkg::DATA_W-1:0]     data;
    logic [7:0]                     status;
    logic                           is_down, is_up, selected;
    logic [trp_pkg::RAW_W-1:0]      raw_sum;
    logic                           frame_done;

    assign in_ready = !frame_valid_reg || frame_ready;
    assign accept   = in_valid && in_ready;
    assign data     = in_byte[trp_pkg::DATA_W-1:0];
    assign status   = in_byte & trp_pkg::STATUS_MASK;
    assign is_down  = (status == trp_pkg::STATUS_DOWN);
    assign is_up    = (status == trp_pkg::STATUS_UP);

    // high*128 + low + 1, max 16384
    assign raw_sum = {1'b0, data, low_reg} + trp_pkg::RAW_W'(1);

    always_comb begin
        unique case (report_mode)
            trp_pkg::MODE_DOWN_ONLY: selected = is_down;
            trp_pkg::MODE_UP_ONLY:   selected = is_up;
            default:                 selected = is_down || is_up;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        low_next   = low_reg;
        x_raw_next = x_raw_reg;
        down_next  = down_reg;
        frame_done = 1'b0;
        if (accept) begin
            unique case (phase_reg)
                PH_X_LO: begin
                    low_next   = data;
                    phase_next = PH_X_HI;
                end
                PH_X_HI: begin
                    x_raw_next = raw_sum;
                    phase_next = PH_Y_LO;
                end
                PH_Y_LO: begin
                    low_next   = data;
                    phase_next = PH_Y_HI;
                end
                PH_Y_HI: begin
                    frame_done = 1'b1;
                    phase_next = PH_IDLE;
                end
                default: begin
                    // idle, also unused codes
                    phase_next = PH_IDLE;
                    if (selected) begin
                        down_next  = is_down;
                        phase_next = PH_X_LO;
                    end
                end
            endcase
        end
    end

    always_comb begin
        frame_valid_next = frame_valid_reg && !frame_ready;
        frame_next       = frame_reg;
        if (frame_done) begin
            frame_valid_next    = 1'b1;
            frame_next.x_raw    = x_raw_reg;
            frame_next.y_raw    = raw_sum;
            frame_next.pen_down = down_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            low_reg         <= '0;
            x_raw_reg       <= '0;
            down_reg        <= 1'b0;
            frame_valid_reg <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            low_reg         <= low_next;
            x_raw_reg       <= x_raw_next;
            down_reg        <= down_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> (phase_reg == PH_IDLE) && frame_valid_reg)
        else $error("parser did not return to idle after final byte");

    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_Y_HI)
        else $error("parser phase left the legal range");

    a_junk_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (phase_reg == PH_IDLE) && !is_down && !is_up |=> phase_reg == PH_IDLE)
        else $error("non-status byte started a report");

endmodule

// ===== design/trp_scale.sv =====
// Pixel scaling: reciprocal multiply per axis into the result register.
module trp_scale (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  trp_pkg::frame_t               frame,
    input  logic [trp_pkg::SCALE_W-1:0]   x_scale,
    input  logic [trp_pkg::SCALE_W-1:0]   y_scale,
    output logic                          out_valid,
    input  logic                          out_ready,
    output trp_pkg::report_t              report
);

    logic [trp_pkg::PROD_W-1:0] x_prod, y_prod;
    logic                       out_valid_reg, out_valid_next;
    trp_pkg::report_t           report_reg, report_next;
    logic                       accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign x_prod = trp_pkg::PROD_W'(frame.x_raw) * trp_pkg::PROD_W'(x_scale);
    assign y_prod = trp_pkg::PROD_W'(frame.y_raw) * trp_pkg::PROD_W'(y_scale);

    always_comb begin
        out_valid_next = out_valid_reg && !out_ready;
        report_next    = report_reg;
        if (accept) begin
            out_valid_next       = 1'b1;
            report_next.x_pixel  = x_prod[trp_pkg::FRAC_W +: trp_pkg::PIXEL_W];
            report_next.y_pixel  = y_prod[trp_pkg::FRAC_W +: trp_pkg::PIXEL_W];
            report_next.pen_down = frame.pen_down;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        report_reg <= report_next;
    end

    assign out_valid = out_valid_reg;
    assign report    = report_reg;

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> out_valid_reg)
        else $error("scaled result lost after load");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> out_valid_reg && !out_ready)
        else $error("scaler stalled without a held result");

endmodule
